>>> hw/rtl/fbpt_pkg.sv
// Package for the base-2 Fermat primality test block.
// Holds width constants, the sequencer state type and the multiplier control struct; no dependencies.
package fbpt_pkg;
  localparam int unsigned CandWidth    = 32;
  localparam int unsigned DefaultWidth = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DBL,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } mul_ctrl_t;
endpackage

>>> hw/rtl/fbpt_stream_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface fbpt_stream_if #(
  parameter int unsigned DataWidth = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/fbpt_mulmod.sv
// Bit-serial modular multiplier: one shift-add-reduce step per cycle.
// Depends on fbpt_pkg.
module fbpt_mulmod import fbpt_pkg::*; #(
  parameter int unsigned Width = DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic [Width-1:0] m_i,
  output mul_ctrl_t        ctrl_o,
  output logic [Width-1:0] p_o
);
  localparam int unsigned CntW = $clog2(Width);

  logic [Width-1:0] acc_q, acc_d, b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [Width:0]   dbl, sum1;
  logic [Width-1:0] r1;

  // Double then conditionally add, each reduced by one compare-subtract.
  always_comb begin
    dbl  = {acc_q, 1'b0};
    r1   = (dbl >= {1'b0, m_i}) ? Width'(dbl - {1'b0, m_i}) : dbl[Width-1:0];
    sum1 = {1'b0, r1} + {1'b0, a_i};
    acc_d = acc_q;
    b_d = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      b_d = b_i;
      cnt_d = CntW'(Width - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = r1;
      if (b_q[Width-1]) begin
        acc_d = (sum1 >= {1'b0, m_i}) ? Width'(sum1 - {1'b0, m_i}) : sum1[Width-1:0];
      end
      b_d = {b_q[Width-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.done  = done_q;
  assign p_o = acc_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ctrl_o.done) else $error("done while busy");
endmodule

>>> hw/rtl/fermat_base2_prime_test.sv
// Base-2 Fermat primality test. One transaction in, one verdict out.
// For odd candidates above 1, each exponent bit takes a square in the bit-serial modular
// multiplier, collection of the product in ST_SQ and a conditional double in ST_DBL.
// A new candidate is taken only after the verdict has moved into the output register.
// Even, zero and one candidates skip the loop and go straight to ST_DONE.
// One candidate at a time. Reset (async, active low) clears the sequencer and output valid.
module fermat_base2_prime_test import fbpt_pkg::*; #(
  parameter int unsigned Width = DefaultWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fbpt_stream_if.sink   cand_i,
  fbpt_stream_if.source verdict_o
);
  localparam int unsigned BitW = $clog2(Width);

  seq_state_e       state_q, state_d;
  logic [Width-1:0] n_q, e_q, r_q, r_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic             res_q, res_d, ovalid_q, ovalid_d;
  logic             out_q, out_d;
  logic             mul_start;
  mul_ctrl_t        mctl;
  logic [Width-1:0] prod;
  logic [Width:0]   r2;
  logic [Width-1:0] cand;
  logic             in_fire;

  assign cand    = cand_i.data[Width-1:0];
  assign in_fire = cand_i.valid && cand_i.ready;
  assign r2      = {r_q, 1'b0};

  // The multiplier latches its b operand at start, so hand it the residue
  // that is about to be registered.
  fbpt_mulmod #(.Width(Width)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(r_q), .b_i(r_d), .m_i(n_q),
    .ctrl_o(mctl), .p_o(prod)
  );

  // Next state: square for every exponent bit, then double if the bit is set.
  always_comb begin
    state_d = state_q;
    r_d = r_q;
    bit_d = bit_q;
    res_d = res_q;
    out_d = out_q;
    ovalid_d = ovalid_q;
    if (verdict_o.valid && verdict_o.ready) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          r_d = Width'(1);
          bit_d = BitW'(Width - 1);
          if (cand == Width'(2)) begin
            res_d = 1'b1; state_d = ST_DONE;
          end else if (!cand[0] || cand == Width'(1)) begin
            res_d = 1'b0; state_d = ST_DONE;
          end else begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (mctl.done) begin
          r_d = prod;
          state_d = ST_DBL;
        end
      end
      ST_DBL: begin
        if (e_q[bit_q]) begin
          r_d = (r2 >= {1'b0, n_q}) ? Width'(r2 - {1'b0, n_q}) : r2[Width-1:0];
        end
        if (bit_q == '0) begin
          res_d = ((e_q[bit_q] ?
                    ((r2 >= {1'b0, n_q}) ? Width'(r2 - {1'b0, n_q}) : r2[Width-1:0])
                    : r_q) == Width'(1));
          state_d = ST_DONE;
        end else begin
          bit_d = bit_q - 1'b1;
          state_d = ST_SQ;
        end
      end
      ST_DONE: begin
        // Move the verdict into the output register once it is free.
        if (!ovalid_q || (verdict_o.valid && verdict_o.ready)) begin
          ovalid_d = 1'b1;
          out_d = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mul_start = 1'b0;
    case (state_q)
      ST_IDLE: mul_start = in_fire && cand[0] && (cand != Width'(1));
      ST_DBL:  mul_start = (bit_q != '0);
      default: mul_start = 1'b0;
    endcase
  end

  assign cand_i.ready   = (state_q == ST_IDLE);
  assign verdict_o.valid = ovalid_q;
  assign verdict_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      bit_q    <= bit_d;
    end
  end

  // Payload: hold candidate and exponent n-1 for the whole transaction.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      n_q <= cand;
      e_q <= cand - Width'(1);
    end
    r_q   <= r_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> !cand_i.ready) else $error("ready while squaring");
  a_odd_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> n_q[0]) else $error("even modulus in loop");
  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DBL) |-> (r_q < n_q)) else $error("residue out of range");
endmodule

>>> bench/fermat_base2_prime_test_tb.sv
// Self-checking bench for the base-2 Fermat primality test block.
// Depends on fbpt_pkg, fbpt_stream_if and fermat_base2_prime_test; drives candidates, checks verdicts.
module fermat_base2_prime_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpt_pkg::*;

  localparam int unsigned NumRandom  = 270;
  localparam int unsigned HoldCycles = 4000;  // long receiver hold-off
  localparam int unsigned DrainWait  = 1200;  // a bit more than one odd-candidate latency

  logic clk_i;
  logic rst_ni;

  fbpt_stream_if #(.DataWidth(CandWidth)) cand_if ();
  fbpt_stream_if #(.DataWidth(1))         verdict_if ();

  fermat_base2_prime_test #(.Width(CandWidth)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cand_i    (cand_if.sink),
    .verdict_o (verdict_if.source)
  );

  // One pending verdict per accepted candidate, oldest first.
  typedef struct {
    logic [CandWidth-1:0] cand;
    logic                 prime;
  } verdict_exp_t;

  verdict_exp_t verdict_exp_q[$];

  // Directed rows: the verdict is typed in only where it is obvious.
  typedef struct {
    logic [CandWidth-1:0] cand;
    bit                   known;
    logic                 prime;
  } cand_row_t;

  int unsigned  mismatches;
  int unsigned  cand_accepts;
  int unsigned  verdicts_seen;
  int unsigned  primes_seen;
  logic [CandWidth-1:0] pending_prime_cand;
  bit           use_typed;
  logic         typed_prime;
  bit           quiet;

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // (a * b) mod m; candidates fit in 32 bits so the product fits in 64.
  function automatic longint unsigned mulmod32(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
    return (a * b) % m;
  endfunction

  // Fermat verdict to base 2, square-and-multiply over the bits of n-1, MSB first.
  function automatic logic fermat2_verdict(logic [CandWidth-1:0] n);
    longint unsigned m;
    longint unsigned e;
    longint unsigned r;
    m = n;
    if (m == 2) return 1'b1;
    if (m[0] == 1'b0) return 1'b0;
    if (m == 1) return 1'b0;
    e = m - 1;
    r = 1;
    for (int i = CandWidth - 1; i >= 0; i--) begin
      r = mulmod32(r, r, m);
      if (e[i]) begin
        r = r + r;
        if (r >= m) r = r - m;
      end
    end
    return (r == 1) ? 1'b1 : 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [CandWidth-1:0] cand,
                                 logic got, logic want);
    $display("MISMATCH %s: candidate %0d got %0b want %0b", what, cand, got, want);
    mismatches++;
  endtask

  // Sample both channels at the rising edge. Push the expectation on input
  // transactions, compare on output transactions.
  always @(posedge clk_i) begin
    verdict_exp_t exp_v;
    if (rst_ni && cand_if.valid && cand_if.ready) begin
      exp_v.cand  = cand_if.data;
      exp_v.prime = use_typed ? typed_prime : fermat2_verdict(cand_if.data);
      verdict_exp_q.push_back(exp_v);
      cand_accepts <= cand_accepts + 1;
    end
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      verdicts_seen <= verdicts_seen + 1;
      if (verdict_exp_q.size() == 0) begin
        report_mismatch("unexpected verdict", '0, verdict_if.data[0], 1'bx);
      end else begin
        exp_v = verdict_exp_q.pop_front();
        if (exp_v.prime) primes_seen <= primes_seen + 1;
        if (verdict_if.data[0] !== exp_v.prime) begin
          report_mismatch("probably_prime", exp_v.cand, verdict_if.data[0], exp_v.prime);
        end
      end
    end
  end

  // Receiver: drop ready about 29% of the time, except while quiet; once,
  // hold ready low for a long stretch so the block fills and stalls its input.
  initial begin
    bit held;
    held = 1'b0;
    verdict_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && cand_accepts >= 40) begin
        held = 1'b1;
        verdict_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      verdict_if.ready = (quiet || $urandom_range(0, 99) >= 29) ? 1'b1 : 1'b0;
    end
  end

  // Offer one candidate and hold it until the block takes it.
  task automatic send_cand(logic [CandWidth-1:0] cand, bit known, logic prime);
    int unsigned seen;
    while (!quiet && $urandom_range(0, 99) < 29) begin
      cand_if.valid = 1'b0;
      @(negedge clk_i);
    end
    use_typed     = known;
    typed_prime   = prime;
    cand_if.data  = cand;
    cand_if.valid = 1'b1;
    seen = cand_accepts;
    @(negedge clk_i);
    while (cand_accepts == seen) @(negedge clk_i);
  endtask

  // Random candidate: mostly odd, many small so primes turn up often.
  function automatic logic [CandWidth-1:0] pick_cand();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom();
    if (sel < 75) return $urandom_range(3, 4000) | 1;
    if (sel < 85) return $urandom() | 1;
    if (sel < 95) return $urandom_range(0, 16);
    return {1'b1, 31'($urandom())} | 1;
  endfunction

  initial begin
    cand_row_t rows[$];
    mismatches    = 0;
    cand_accepts  = 0;
    verdicts_seen = 0;
    primes_seen   = 0;
    use_typed     = 1'b0;
    typed_prime   = 1'b0;
    quiet         = 1'b0;
    cand_if.valid = 1'b0;
    cand_if.data  = '0;
    rst_ni        = 1'b0;

    // Extremes, the zero/one/two cases, even numbers, a few primes and
    // base-2 pseudoprimes (which pass the test by definition).
    rows = '{
      '{32'd0,          1'b1, 1'b0},
      '{32'd1,          1'b1, 1'b0},
      '{32'd2,          1'b1, 1'b1},
      '{32'd3,          1'b0, 1'b0},
      '{32'd4,          1'b1, 1'b0},
      '{32'd5,          1'b0, 1'b0},
      '{32'd9,          1'b0, 1'b0},
      '{32'd341,        1'b1, 1'b1},
      '{32'd561,        1'b1, 1'b1},
      '{32'd645,        1'b0, 1'b0},
      '{32'hFFFF_FFFE,  1'b1, 1'b0},
      '{32'hFFFF_FFFF,  1'b0, 1'b0},
      '{32'hFFFF_FFFB,  1'b1, 1'b1},
      '{32'h8000_0000,  1'b1, 1'b0},
      '{32'h8000_0001,  1'b0, 1'b0},
      '{32'h7FFF_FFFF,  1'b1, 1'b1},
      '{32'hAAAA_AAAB,  1'b0, 1'b0},
      '{32'h5555_5555,  1'b0, 1'b0},
      '{32'd65537,      1'b1, 1'b1},
      '{32'd1105,       1'b0, 1'b0}
    };

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_cand(rows[i].cand, rows[i].known, rows[i].prime);

    for (int unsigned i = 0; i < NumRandom; i++) begin
      quiet = (i >= 100 && i < 160);
      // Pause once until every pending verdict is back.
      if (i == 200) begin
        cand_if.valid = 1'b0;
        while (verdict_exp_q.size() != 0) @(negedge clk_i);
      end
      send_cand(pick_cand(), 1'b0, 1'b0);
    end
    quiet         = 1'b0;
    cand_if.valid = 1'b0;
    use_typed     = 1'b0;

    while (verdict_exp_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("Covered %0d candidates (%0d directed), %0d verdicts, %0d probably prime.",
             cand_accepts, rows.size(), verdicts_seen, primes_seen);
    $display("Included a long output stall and a full drain mid-run.");
    if (mismatches == 0 && verdict_exp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50ms;
    $display("Timeout with %0d verdicts pending", verdict_exp_q.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
